// ===== rtl/core/fsap_pkg.sv =====
// ----------------------------------------------------------------------------
// fsap_pkg
// Shared types, sizes and command codes for the five-stage ALU pipeline.
// ----------------------------------------------------------------------------
package fsap_pkg;

  // Register file geometry and datapath width
  localparam int REG_COUNT  = 32;
  localparam int DATA_WIDTH = 32;
  localparam int RF_ADDR_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Field widths of one instruction and one writeback report
  localparam int CMD_W     = 3;
  localparam int REG_IDX_W = 5;
  localparam int IMM_W     = 8;
  localparam int OUT_VAL_W = 32;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Command codes; anything above CMD_SUBI neither reads nor writes
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADDI = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUBI = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NOP  = 3'd4;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;
  typedef logic [CMD_W-1:0]      cmd_t;

  // Commands that produce a register write
  function automatic logic is_write_cmd(input cmd_t cmd);
    return (cmd == CMD_ADD) || (cmd == CMD_ADDI) || (cmd == CMD_SUB) || (cmd == CMD_SUBI);
  endfunction

  // Commands whose second operand is the immediate
  function automatic logic is_imm_cmd(input cmd_t cmd);
    return (cmd == CMD_ADDI) || (cmd == CMD_SUBI);
  endfunction

  // Register index that maps onto an existing register
  function automatic logic idx_in_range(input reg_idx_t idx);
    return 32'(idx) < REG_COUNT;
  endfunction

endpackage

// ===== rtl/core/fsap_ram.sv =====
// ----------------------------------------------------------------------------
// fsap_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fsap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/five_stage_alu_pipeline.sv =====
// Latency: the writeback of the instruction in transaction n is reported in result
//   transaction n+4; a result is registered out in the cycle after its input is taken.
// Throughput: one transaction per cycle unless out_tready stalls, set by the two register
//   file RAM read ports and the single write port, forwarding around current and last-edge writes.
// Reset: all stages hold no write and the register file reads as zero through
//   per-register valid bits; there is no clearing pass, input is taken right after reset.
// ----------------------------------------------------------------------------
// five_stage_alu_pipeline
// Fetch, decode, execute, memory and writeback registers around a RAM-based
// register file; the pipeline advances by one stage per accepted transaction.
// ----------------------------------------------------------------------------
module five_stage_alu_pipeline (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: dest_reg[4:0], src_reg_a[9:5], src_reg_b[14:10], immediate[22:15]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fsap_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: command[2:0]
  input  logic [fsap_pkg::CMD_W-1:0]      in_tuser,
  // out_tdata: write_reg[4:0], write_value[36:5]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fsap_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: write_enable[0]
  output logic                            out_tuser
);

  import fsap_pkg::*;

  // Fetch stage
  cmd_t                    fe_cmd_r;
  reg_idx_t                fe_dest_r, fe_src_a_r, fe_src_b_r;
  logic signed [IMM_W-1:0] fe_imm_r;
  // Decode stage
  cmd_t                    de_cmd_r;
  reg_idx_t                de_dest_r;
  data_t                   de_opa_r, de_opb_r;
  // Execute and memory stages
  logic                    ex_wr_r, mem_wr_r;
  reg_idx_t                ex_dest_r, mem_dest_r;
  data_t                   ex_value_r, mem_value_r;
  // Output register
  logic                    out_valid_r;
  logic                    out_we_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  // Register file bookkeeping
  logic [REG_COUNT-1:0]    rf_valid_r;
  logic                    byp_en_r;
  reg_idx_t                byp_idx_r;
  data_t                   byp_data_r;

  logic                    accept;
  logic                    wb_we;
  logic [RF_ADDR_W-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  data_t                   rd_data_a, rd_data_b;
  data_t                   opa_nxt, opb_nxt, src_a_val, src_b_val, imm_ext;
  data_t                   ex_value_nxt;

  // Handshake: the output register frees up when its transaction is taken
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  // Writeback happens on the edge that accepts a transaction
  assign wb_we   = accept && mem_wr_r && idx_in_range(mem_dest_r);
  assign wr_addr = RF_ADDR_W'(mem_dest_r);

  // Read addresses follow the instruction that will sit in fetch
  assign rd_addr_a = accept ? RF_ADDR_W'(in_tdata[9:5])   : RF_ADDR_W'(fe_src_a_r);
  assign rd_addr_b = accept ? RF_ADDR_W'(in_tdata[14:10]) : RF_ADDR_W'(fe_src_b_r);

  fsap_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (wb_we),
    .waddr (wr_addr),
    .wdata (mem_value_r),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  fsap_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (wb_we),
    .waddr (wr_addr),
    .wdata (mem_value_r),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  // Resolve source operands: current writeback, last edge's write, RAM, or zero
  always_comb begin
    if (!idx_in_range(fe_src_a_r)) begin
      src_a_val = '0;
    end else if (wb_we && (mem_dest_r == fe_src_a_r)) begin
      src_a_val = mem_value_r;
    end else if (byp_en_r && (byp_idx_r == fe_src_a_r)) begin
      src_a_val = byp_data_r;
    end else if (rf_valid_r[RF_ADDR_W'(fe_src_a_r)]) begin
      src_a_val = rd_data_a;
    end else begin
      src_a_val = '0;
    end

    if (!idx_in_range(fe_src_b_r)) begin
      src_b_val = '0;
    end else if (wb_we && (mem_dest_r == fe_src_b_r)) begin
      src_b_val = mem_value_r;
    end else if (byp_en_r && (byp_idx_r == fe_src_b_r)) begin
      src_b_val = byp_data_r;
    end else if (rf_valid_r[RF_ADDR_W'(fe_src_b_r)]) begin
      src_b_val = rd_data_b;
    end else begin
      src_b_val = '0;
    end
  end

  // Decode: pick register or sign-extended immediate operands
  assign imm_ext = DATA_WIDTH'(fe_imm_r);

  always_comb begin
    if (is_write_cmd(fe_cmd_r)) begin
      opa_nxt = src_a_val;
      opb_nxt = is_imm_cmd(fe_cmd_r) ? imm_ext : src_b_val;
    end else begin
      opa_nxt = '0;
      opb_nxt = '0;
    end
  end

  // Execute: wrapping add or subtract
  always_comb begin
    case (de_cmd_r)
      CMD_ADD, CMD_ADDI: ex_value_nxt = de_opa_r + de_opb_r;
      CMD_SUB, CMD_SUBI: ex_value_nxt = de_opa_r - de_opb_r;
      default:           ex_value_nxt = '0;
    endcase
  end

  // Control state: stage write flags, commands, valid bits, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_cmd_r    <= CMD_NOP;
      de_cmd_r    <= CMD_NOP;
      ex_wr_r     <= 1'b0;
      mem_wr_r    <= 1'b0;
      rf_valid_r  <= '0;
      byp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_we_r    <= 1'b0;
    end else begin
      byp_en_r <= wb_we;
      if (wb_we) begin
        rf_valid_r[wr_addr] <= 1'b1;
      end
      if (accept) begin
        fe_cmd_r    <= in_tuser;
        de_cmd_r    <= fe_cmd_r;
        ex_wr_r     <= is_write_cmd(de_cmd_r);
        mem_wr_r    <= ex_wr_r;
        out_valid_r <= 1'b1;
        out_we_r    <= wb_we;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: latch the bypass write each cycle; advance stage data on each accepted transaction
  always_ff @(posedge clk) begin
    byp_idx_r  <= mem_dest_r;
    byp_data_r <= mem_value_r;
    if (accept) begin
      fe_dest_r   <= in_tdata[4:0];
      fe_src_a_r  <= in_tdata[9:5];
      fe_src_b_r  <= in_tdata[14:10];
      fe_imm_r    <= in_tdata[22:15];
      de_dest_r   <= fe_dest_r;
      de_opa_r    <= opa_nxt;
      de_opb_r    <= opb_nxt;
      ex_dest_r   <= de_dest_r;
      ex_value_r  <= ex_value_nxt;
      mem_dest_r  <= ex_dest_r;
      mem_value_r <= ex_value_r;
      if (wb_we) begin
        out_data_r <= {3'b000, OUT_VAL_W'(mem_value_r), mem_dest_r};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_we_r;

endmodule
